[design/r1mu_pkg.sv]
// shared types, codes and saturation helper for the rank-one matrix update block
package r1mu_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int REQ_W     = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_X   = 3'd0,
    REQ_WR_Y   = 3'd1,
    REQ_WR_A   = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_RD_A   = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA     = 3'd0,
    CFG_ROW_FIRST = 3'd1,
    CFG_ROW_END   = 3'd2,
    CFG_COL_FIRST = 3'd3,
    CFG_COL_END   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y_RD,
    ST_COEF_MUL,
    ST_COEF_SAT,
    ST_ROW_RUN,
    ST_DRAIN
  } state_t;

  // sequencer to arithmetic pipeline
  typedef struct packed {
    logic y_vld;
    logic coef_sat;
    logic issue;
    logic acc_clear;
  } dp_ctl_t;

  // arithmetic pipeline back to sequencer and top level
  typedef struct packed {
    logic pipe_busy;
    logic clip;
  } dp_sts_t;

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] val;
  } sat_res_t;

  // clip a 49-bit signed value into signed 32 bits
  function automatic sat_res_t sat32(input logic signed [48:0] v);
    sat_res_t res;
    res.clip = !((&v[48:31]) || !(|v[48:31]));
    if (!res.clip) begin
      res.val = v[31:0];
    end else if (v[48]) begin
      res.val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[design/r1mu_ram.sv]
// generic simple dual-port ram with registered read
module r1mu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/r1mu_ctrl.sv]
// update sequencer: window walk, column coefficient steps and row issue
module r1mu_ctrl #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd_go,
  input  logic [r1mu_pkg::CFG_W-1:0]  row_first,
  input  logic [r1mu_pkg::CFG_W-1:0]  row_end,
  input  logic [r1mu_pkg::CFG_W-1:0]  col_first,
  input  logic [r1mu_pkg::CFG_W-1:0]  col_end,
  input  r1mu_pkg::dp_sts_t           sts,
  output logic                        busy,
  output logic                        done,
  output r1mu_pkg::dp_ctl_t           ctl,
  output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]               x_raddr,
  output logic [(COLS > 1 ? $clog2(COLS) : 1)-1:0]               y_raddr,
  output logic [(ROWS*COLS > 1 ? $clog2(ROWS*COLS) : 1)-1:0]     a_raddr
);

  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int MAW  = (ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1;
  localparam int RCW  = $clog2(ROWS + 1);
  localparam int CCW  = $clog2(COLS + 1);
  localparam int RLW  = (RCW > r1mu_pkg::CFG_W) ? RCW : r1mu_pkg::CFG_W;
  localparam int CLW  = (CCW > r1mu_pkg::CFG_W) ? CCW : r1mu_pkg::CFG_W;
  localparam logic [RLW-1:0] ROWS_L = RLW'(ROWS);
  localparam logic [CLW-1:0] COLS_L = CLW'(COLS);

  r1mu_pkg::state_t state_r, state_nxt;
  logic [RLW-1:0] row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [RLW-1:0] rf_e, re_e, re_w;
  logic [CLW-1:0] cf_e, ce_e, ce_w;
  logic           empty, last_row, last_col;
  logic [RLW:0]   row_inc;
  logic [CLW:0]   col_inc;

  always_comb begin
    rf_e     = RLW'(row_first);
    re_e     = RLW'(row_end);
    cf_e     = CLW'(col_first);
    ce_e     = CLW'(col_end);
    re_w     = (re_e < ROWS_L) ? re_e : ROWS_L;
    ce_w     = (ce_e < COLS_L) ? ce_e : COLS_L;
    empty    = (rf_e >= re_w) || (cf_e >= ce_w);
    row_inc  = {1'b0, row_r} + (RLW+1)'(1);
    col_inc  = {1'b0, col_r} + (CLW+1)'(1);
    last_row = row_inc >= {1'b0, re_w};
    last_col = col_inc >= {1'b0, ce_w};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      r1mu_pkg::ST_IDLE: begin
        if (upd_go && !empty) state_nxt = r1mu_pkg::ST_Y_RD;
      end
      r1mu_pkg::ST_Y_RD:     state_nxt = r1mu_pkg::ST_COEF_MUL;
      r1mu_pkg::ST_COEF_MUL: state_nxt = r1mu_pkg::ST_COEF_SAT;
      r1mu_pkg::ST_COEF_SAT: state_nxt = r1mu_pkg::ST_ROW_RUN;
      r1mu_pkg::ST_ROW_RUN: begin
        if (last_row) state_nxt = r1mu_pkg::ST_DRAIN;
      end
      r1mu_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = last_col ? r1mu_pkg::ST_IDLE : r1mu_pkg::ST_Y_RD;
        end
      end
      default: state_nxt = r1mu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    done          = 1'b0;
    ctl           = '0;
    ctl.acc_clear = 1'b0;
    case (state_r)
      r1mu_pkg::ST_IDLE: begin
        busy          = 1'b0;
        ctl.acc_clear = upd_go;
        done          = upd_go && empty;
      end
      r1mu_pkg::ST_Y_RD:     ;
      r1mu_pkg::ST_COEF_MUL: ctl.y_vld = 1'b1;
      r1mu_pkg::ST_COEF_SAT: ctl.coef_sat = 1'b1;
      r1mu_pkg::ST_ROW_RUN:  ctl.issue = 1'b1;
      r1mu_pkg::ST_DRAIN:    done = !sts.pipe_busy && last_col;
      default:               busy = 1'b0;
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (state_r == r1mu_pkg::ST_IDLE && upd_go) begin
      row_nxt = rf_e;
      col_nxt = cf_e;
    end else if (state_r == r1mu_pkg::ST_ROW_RUN && !last_row) begin
      row_nxt = row_inc[RLW-1:0];
    end else if (state_r == r1mu_pkg::ST_DRAIN && !sts.pipe_busy && !last_col) begin
      row_nxt = rf_e;
      col_nxt = col_inc[CLW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= r1mu_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // column-major matrix layout
  assign x_raddr = row_r[RAW-1:0];
  assign y_raddr = col_r[CAW-1:0];
  assign a_raddr = MAW'(col_r) * MAW'(ROWS) + MAW'(row_r);

  ap_issue_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == r1mu_pkg::ST_ROW_RUN |-> row_r < re_w && col_r < ce_w)
    else $error("row issued outside the window");
  ap_drain_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == r1mu_pkg::ST_ROW_RUN && last_row |=> state_r == r1mu_pkg::ST_DRAIN)
    else $error("last row not followed by drain");
  ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == r1mu_pkg::ST_IDLE)
    else $error("done without returning to idle");

endmodule

[design/r1mu_dp.sv]
// arithmetic pipeline: column coefficient and per-element multiply, add, saturate
module r1mu_dp #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  r1mu_pkg::dp_ctl_t                            ctl,
  input  logic signed [r1mu_pkg::DATA_W-1:0]           alpha,
  input  logic signed [r1mu_pkg::DATA_W-1:0]           y_rdata,
  input  logic signed [r1mu_pkg::DATA_W-1:0]           x_rdata,
  input  logic signed [r1mu_pkg::DATA_W-1:0]           a_rdata,
  input  logic [(ROWS*COLS > 1 ? $clog2(ROWS*COLS) : 1)-1:0] issue_addr,
  output logic                                         a_we,
  output logic [(ROWS*COLS > 1 ? $clog2(ROWS*COLS) : 1)-1:0] a_waddr,
  output logic [r1mu_pkg::DATA_W-1:0]                  a_wdata,
  output r1mu_pkg::dp_sts_t                            sts
);

  localparam int MAW = (ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1;
  localparam int PW  = 2 * r1mu_pkg::DATA_W;

  logic signed [PW-1:0]              coef_prod_r;
  logic signed [r1mu_pkg::DATA_W-1:0] coef_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [r1mu_pkg::DATA_W-1:0] a_hold_r;
  logic                              s1_v_r, s2_v_r, clip_r;
  logic [MAW-1:0]                    s1_addr_r, s2_addr_r;
  logic signed [PW-1:0]              coef_sh, prod_sh;
  logic signed [48:0]                coef_w, sum_w;
  r1mu_pkg::sat_res_t                coef_sat, sum_sat;

  always_comb begin
    // arithmetic shift drops the low 16 bits: floor division
    coef_sh  = coef_prod_r >>> 16;
    prod_sh  = prod_r >>> 16;
    coef_w   = coef_sh[48:0];
    sum_w    = prod_sh[48:0] + {{17{a_hold_r[r1mu_pkg::DATA_W-1]}}, a_hold_r};
    coef_sat = r1mu_pkg::sat32(coef_w);
    sum_sat  = r1mu_pkg::sat32(sum_w);
  end

  always_ff @(posedge clk) begin
    if (ctl.y_vld) begin
      coef_prod_r <= alpha * y_rdata;
    end
    if (ctl.coef_sat) begin
      coef_r <= coef_sat.val;
    end
    if (s1_v_r) begin
      prod_r   <= x_rdata * coef_r;
      a_hold_r <= a_rdata;
    end
    s1_addr_r <= issue_addr;
    s2_addr_r <= s1_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      clip_r <= 1'b0;
    end else begin
      s1_v_r <= ctl.issue;
      s2_v_r <= s1_v_r;
      if (ctl.acc_clear) begin
        clip_r <= 1'b0;
      end else if ((ctl.coef_sat && coef_sat.clip) || (s2_v_r && sum_sat.clip)) begin
        clip_r <= 1'b1;
      end
    end
  end

  assign a_we          = s2_v_r;
  assign a_waddr       = s2_addr_r;
  assign a_wdata       = sum_sat.val;
  assign sts.pipe_busy = s1_v_r || s2_v_r;
  assign sts.clip      = clip_r;

  ap_coef_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.coef_sat |-> !s1_v_r && !s2_v_r)
    else $error("coefficient changed while elements in flight");
  ap_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("element lost between pipeline stages");

endmodule

[design/rank_one_matrix_update.sv]
// top level of the rank-one matrix update block: config registers, request decode, rams
//
//  channel   ports                                      handshake
//  request   in_req_type in_row in_col in_value         start & !busy
//  result    out_read_value out_saturated               out_valid, one cycle, no stall
//  config    cfg_index cfg_data                         cfg_we, no wait
//
// loads and reads: a request per cycle while busy is low, its result in the cycle after acceptance
// update runs over the clipped window, busy high throughout, result in the same cycle
// that busy falls; paced by the shared matrix ram ports and the
// two-stage multiply, add and saturate pipeline which drains at the end of each column
// an empty window answers in the cycle after acceptance without raising busy
// reset needs no clearing pass; results cannot be held off by the receiver
module rank_one_matrix_update #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [r1mu_pkg::REQ_W-1:0]               in_req_type,
  input  logic [r1mu_pkg::IDX_W-1:0]               in_row,
  input  logic [r1mu_pkg::IDX_W-1:0]               in_col,
  input  logic signed [r1mu_pkg::DATA_W-1:0]       in_value,
  output logic                                     out_valid,
  output logic signed [r1mu_pkg::DATA_W-1:0]       out_read_value,
  output logic                                     out_saturated,
  input  logic                                     cfg_we,
  input  logic [r1mu_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [r1mu_pkg::DATA_W-1:0]              cfg_data
);

  localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int MAW = (ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1;
  localparam int RCW = $clog2(ROWS + 1);
  localparam int CCW = $clog2(COLS + 1);
  localparam int RLW = (RCW > r1mu_pkg::IDX_W) ? RCW : r1mu_pkg::IDX_W;
  localparam int CLW = (CCW > r1mu_pkg::IDX_W) ? CCW : r1mu_pkg::IDX_W;
  localparam logic [RLW-1:0] ROWS_L = RLW'(ROWS);
  localparam logic [CLW-1:0] COLS_L = CLW'(COLS);

  logic signed [r1mu_pkg::DATA_W-1:0] alpha_r;
  logic [r1mu_pkg::CFG_W-1:0] row_first_r, row_end_r, col_first_r, col_end_r;

  r1mu_pkg::req_t    req;
  r1mu_pkg::dp_ctl_t ctl;
  r1mu_pkg::dp_sts_t sts;

  logic           accept, row_ok, col_ok, upd_go, done;
  logic           resp_r, rd_sel_r;
  logic           x_we, y_we, a_req_we, dp_a_we, a_we;
  logic [MAW-1:0] req_addr, ctl_a_raddr, a_raddr, dp_a_waddr, a_waddr;
  logic [RAW-1:0] ctl_x_raddr;
  logic [CAW-1:0] ctl_y_raddr;
  logic [r1mu_pkg::DATA_W-1:0] dp_a_wdata, a_wdata;
  logic signed [r1mu_pkg::DATA_W-1:0] x_rdata, y_rdata, a_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= 32'sd65536;
      row_first_r <= '0;
      row_end_r   <= 7'd64;
      col_first_r <= '0;
      col_end_r   <= 7'd64;
    end else if (cfg_we) begin
      case (r1mu_pkg::cfg_idx_t'(cfg_index))
        r1mu_pkg::CFG_ALPHA:     alpha_r     <= cfg_data;
        r1mu_pkg::CFG_ROW_FIRST: row_first_r <= cfg_data[r1mu_pkg::CFG_W-1:0];
        r1mu_pkg::CFG_ROW_END:   row_end_r   <= cfg_data[r1mu_pkg::CFG_W-1:0];
        r1mu_pkg::CFG_COL_FIRST: col_first_r <= cfg_data[r1mu_pkg::CFG_W-1:0];
        r1mu_pkg::CFG_COL_END:   col_end_r   <= cfg_data[r1mu_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  always_comb begin
    accept   = start && !busy;
    req      = r1mu_pkg::req_t'(in_req_type);
    row_ok   = RLW'(in_row) < ROWS_L;
    col_ok   = CLW'(in_col) < COLS_L;
    req_addr = MAW'(in_col) * MAW'(ROWS) + MAW'(in_row);
    x_we     = 1'b0;
    y_we     = 1'b0;
    a_req_we = 1'b0;
    upd_go   = 1'b0;
    if (accept) begin
      case (req)
        r1mu_pkg::REQ_WR_X:   x_we     = row_ok;
        r1mu_pkg::REQ_WR_Y:   y_we     = col_ok;
        r1mu_pkg::REQ_WR_A:   a_req_we = row_ok && col_ok;
        r1mu_pkg::REQ_UPDATE: upd_go   = 1'b1;
        r1mu_pkg::REQ_RD_A:   ;
        default: ;
      endcase
    end
  end

  // the update pipeline owns the matrix ports while busy
  assign a_we    = a_req_we || dp_a_we;
  assign a_waddr = dp_a_we ? dp_a_waddr : req_addr;
  assign a_wdata = dp_a_we ? dp_a_wdata : in_value;
  assign a_raddr = busy ? ctl_a_raddr : req_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r   <= 1'b0;
      rd_sel_r <= 1'b0;
    end else begin
      resp_r   <= (accept && req != r1mu_pkg::REQ_UPDATE) || done;
      rd_sel_r <= accept && req == r1mu_pkg::REQ_RD_A && row_ok && col_ok;
    end
  end

  assign out_valid      = resp_r;
  assign out_read_value = rd_sel_r ? a_rdata : '0;
  assign out_saturated  = sts.clip;

  r1mu_ram #(.WIDTH(r1mu_pkg::DATA_W), .DEPTH(ROWS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (RAW'(in_row)),
    .wdata (in_value),
    .raddr (ctl_x_raddr),
    .rdata (x_rdata)
  );

  r1mu_ram #(.WIDTH(r1mu_pkg::DATA_W), .DEPTH(COLS)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (CAW'(in_col)),
    .wdata (in_value),
    .raddr (ctl_y_raddr),
    .rdata (y_rdata)
  );

  r1mu_ram #(.WIDTH(r1mu_pkg::DATA_W), .DEPTH(ROWS*COLS)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  r1mu_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_go    (upd_go),
    .row_first (row_first_r),
    .row_end   (row_end_r),
    .col_first (col_first_r),
    .col_end   (col_end_r),
    .sts       (sts),
    .busy      (busy),
    .done      (done),
    .ctl       (ctl),
    .x_raddr   (ctl_x_raddr),
    .y_raddr   (ctl_y_raddr),
    .a_raddr   (ctl_a_raddr)
  );

  r1mu_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .alpha      (alpha_r),
    .y_rdata    (y_rdata),
    .x_rdata    (x_rdata),
    .a_rdata    (a_rdata),
    .issue_addr (ctl_a_raddr),
    .a_we       (dp_a_we),
    .a_waddr    (dp_a_waddr),
    .a_wdata    (dp_a_wdata),
    .sts        (sts)
  );

  ap_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe during an update");
  ap_simple_request_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req != r1mu_pkg::REQ_UPDATE |=> out_valid)
    else $error("request not answered in the next cycle");
  ap_update_write_owned: assert property (@(posedge clk) disable iff (!rst_n)
    dp_a_we |-> busy && !a_req_we)
    else $error("update write-back collides with a request write");

endmodule

[dv/rank_one_matrix_update_tb.sv]
// self-checking testbench for the rank-one matrix update block: random loads, updates, reads
`timescale 1ns / 1ps

module rank_one_matrix_update_tb;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int ITEM_TARGET = 1000;

  localparam logic [r1mu_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [r1mu_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  localparam logic signed [r1mu_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [r1mu_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [r1mu_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    logic [r1mu_pkg::REQ_W-1:0]         kind;
    logic [r1mu_pkg::IDX_W-1:0]         row;
    logic [r1mu_pkg::IDX_W-1:0]         col;
    logic signed [r1mu_pkg::DATA_W-1:0] value;
  } mat_req_t;

  typedef struct {
    logic signed [r1mu_pkg::DATA_W-1:0] read_value;
    logic                               saturated;
  } mat_result_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic [r1mu_pkg::REQ_W-1:0]         in_req_type = '0;
  logic [r1mu_pkg::IDX_W-1:0]         in_row = '0;
  logic [r1mu_pkg::IDX_W-1:0]         in_col = '0;
  logic signed [r1mu_pkg::DATA_W-1:0] in_value = '0;
  logic                               out_valid;
  logic signed [r1mu_pkg::DATA_W-1:0] out_read_value;
  logic                               out_saturated;
  logic                               cfg_we = 1'b0;
  logic [r1mu_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [r1mu_pkg::DATA_W-1:0]        cfg_data = '0;

  rank_one_matrix_update #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // mirror of the block's stores and registers
  logic signed [r1mu_pkg::DATA_W-1:0] mat_mirror [ROWS][COLS];
  logic signed [r1mu_pkg::DATA_W-1:0] x_mirror [ROWS];
  logic signed [r1mu_pkg::DATA_W-1:0] y_mirror [COLS];
  logic                               clip_mirror = 1'b0;
  logic signed [r1mu_pkg::DATA_W-1:0] alpha_reg = Q_ONE;
  int                                 row_first_reg = 0;
  int                                 row_end_reg = ROWS;
  int                                 col_first_reg = 0;
  int                                 col_end_reg = COLS;

  // entries that some queued request has written, tracked at generation time
  bit x_set [ROWS];
  bit y_set [COLS];
  bit a_set [ROWS][COLS];

  mat_req_t    request_queue[$];
  mat_result_t pending_results[$];

  int     mismatch_count = 0;
  int     queued_items = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  longint cycle_count = 0;
  longint cycle_budget = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [r1mu_pkg::DATA_W-1:0] clamp_q16(input longint v,
                                                                   inout logic clipped);
    if (v > longint'(Q_MAX)) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return v[r1mu_pkg::DATA_W-1:0];
  endfunction

  function automatic mat_result_t ger_request(input mat_req_t rq);
    mat_result_t                        res;
    int                                 re;
    int                                 ce;
    logic                               clipped;
    logic signed [r1mu_pkg::DATA_W-1:0] coef;
    longint                             prod;
    res.read_value = '0;
    case (rq.kind)
      r1mu_pkg::REQ_WR_X: x_mirror[rq.row] = rq.value;
      r1mu_pkg::REQ_WR_Y: y_mirror[rq.col] = rq.value;
      r1mu_pkg::REQ_WR_A: mat_mirror[rq.row][rq.col] = rq.value;
      r1mu_pkg::REQ_RD_A: res.read_value = mat_mirror[rq.row][rq.col];
      r1mu_pkg::REQ_UPDATE: begin
        re = (row_end_reg < ROWS) ? row_end_reg : ROWS;
        ce = (col_end_reg < COLS) ? col_end_reg : COLS;
        clipped = 1'b0;
        // a clipped coefficient only counts when its column has rows to update
        if (row_first_reg < re) begin
          for (int c = col_first_reg; c < ce; c++) begin
            coef = clamp_q16((longint'(alpha_reg) * longint'(y_mirror[c])) >>> 16, clipped);
            for (int r = row_first_reg; r < re; r++) begin
              prod = (longint'(x_mirror[r]) * longint'(coef)) >>> 16;
              mat_mirror[r][c] = clamp_q16(longint'(mat_mirror[r][c]) + prod, clipped);
            end
          end
        end
        clip_mirror = clipped;
      end
      default: ;
    endcase
    res.saturated = clip_mirror;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("%0t ns mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic signed [r1mu_pkg::DATA_W-1:0] rand_q16();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    end else if (sel < 6) begin
      return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    end else if (sel < 8) begin
      return $urandom;
    end
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ONE;
      3: return -Q_ONE;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic void queue_req(input logic [r1mu_pkg::REQ_W-1:0] kind, input int row,
                                    input int col,
                                    input logic signed [r1mu_pkg::DATA_W-1:0] value);
    mat_req_t rq;
    rq.kind  = kind;
    rq.row   = row[r1mu_pkg::IDX_W-1:0];
    rq.col   = col[r1mu_pkg::IDX_W-1:0];
    rq.value = value;
    request_queue.push_back(rq);
    queued_items++;
    cycle_budget += 12;
    case (kind)
      r1mu_pkg::REQ_WR_X: x_set[rq.row] = 1'b1;
      r1mu_pkg::REQ_WR_Y: y_set[rq.col] = 1'b1;
      r1mu_pkg::REQ_WR_A: a_set[rq.row][rq.col] = 1'b1;
      r1mu_pkg::REQ_UPDATE: begin
        if (row_first_reg < row_end_reg && col_first_reg < col_end_reg) begin
          cycle_budget += (col_end_reg - col_first_reg) * (row_end_reg - row_first_reg + 6) + 4;
        end
      end
      default: ;
    endcase
  endfunction

  // never read an element nobody wrote
  function automatic void queue_read(input int row, input int col);
    if (!a_set[row][col]) begin
      queue_req(r1mu_pkg::REQ_WR_A, row, col, rand_q16());
    end
    queue_req(r1mu_pkg::REQ_RD_A, row, col, rand_q16());
  endfunction

  function automatic void fill_window();
    if (row_first_reg >= row_end_reg || col_first_reg >= col_end_reg) begin
      return;
    end
    for (int r = row_first_reg; r < row_end_reg; r++) begin
      if (!x_set[r]) queue_req(r1mu_pkg::REQ_WR_X, r, $urandom_range(0, COLS - 1), rand_q16());
    end
    for (int c = col_first_reg; c < col_end_reg; c++) begin
      if (!y_set[c]) queue_req(r1mu_pkg::REQ_WR_Y, $urandom_range(0, ROWS - 1), c, rand_q16());
    end
    for (int c = col_first_reg; c < col_end_reg; c++) begin
      for (int r = row_first_reg; r < row_end_reg; r++) begin
        if (!a_set[r][c]) queue_req(r1mu_pkg::REQ_WR_A, r, c, rand_q16());
      end
    end
  endfunction

  function automatic int pick_row();
    if (row_first_reg < row_end_reg && $urandom_range(0, 9) < 7) begin
      return $urandom_range(row_first_reg, row_end_reg - 1);
    end
    return $urandom_range(0, ROWS - 1);
  endfunction

  function automatic int pick_col();
    if (col_first_reg < col_end_reg && $urandom_range(0, 9) < 7) begin
      return $urandom_range(col_first_reg, col_end_reg - 1);
    end
    return $urandom_range(0, COLS - 1);
  endfunction

  task automatic pick_span(input int span, output int lo, output int hi);
    case ($urandom_range(0, 7))
      0: begin
        lo = $urandom_range(0, span);
        hi = $urandom_range(0, lo);
      end
      1: begin
        lo = 0;
        hi = $urandom_range(1, 3);
      end
      2: begin
        hi = span;
        lo = $urandom_range(span - 3, span - 1);
      end
      default: begin
        lo = $urandom_range(0, span - 1);
        hi = lo + $urandom_range(1, 7);
        if (hi > span) hi = span;
      end
    endcase
  endtask

  // sampled on the falling edge so the rising-edge updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || start || pending_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input r1mu_pkg::cfg_idx_t idx,
                           input logic [r1mu_pkg::DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      r1mu_pkg::CFG_ALPHA:     alpha_reg = data;
      r1mu_pkg::CFG_ROW_FIRST: row_first_reg = data[r1mu_pkg::CFG_W-1:0];
      r1mu_pkg::CFG_ROW_END:   row_end_reg = data[r1mu_pkg::CFG_W-1:0];
      r1mu_pkg::CFG_COL_FIRST: col_first_reg = data[r1mu_pkg::CFG_W-1:0];
      r1mu_pkg::CFG_COL_END:   col_end_reg = data[r1mu_pkg::CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [r1mu_pkg::DATA_W-1:0] alpha, input int rf,
                            input int re, input int cf, input int ce);
    wait_idle();
    write_reg(r1mu_pkg::CFG_ALPHA, alpha);
    write_reg(r1mu_pkg::CFG_ROW_FIRST, rf);
    write_reg(r1mu_pkg::CFG_ROW_END, re);
    write_reg(r1mu_pkg::CFG_COL_FIRST, cf);
    write_reg(r1mu_pkg::CFG_COL_END, ce);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin : driver
    mat_req_t taken;
    mat_req_t nxt;
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (start && !busy) begin
        taken.kind  = in_req_type;
        taken.row   = in_row;
        taken.col   = in_col;
        taken.value = in_value;
        pending_results.push_back(ger_request(taken));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (request_queue.size() > 0) begin
          nxt = request_queue.pop_front();
          in_req_type <= nxt.kind;
          in_row      <= nxt.row;
          in_col      <= nxt.col;
          in_value    <= nxt.value;
          start       <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    mat_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          report_mismatch($sformatf("read_value %h, expected %h", out_read_value,
                                    want.read_value));
        end
        if (out_saturated !== want.saturated) begin
          report_mismatch($sformatf("saturated %b, expected %b", out_saturated,
                                    want.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("** rank_one_matrix_update: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int                                 rf;
    int                                 re;
    int                                 cf;
    int                                 ce;
    int                                 n;
    int                                 sel;
    int                                 code;
    int                                 phase;
    bit                                 tall;
    logic signed [r1mu_pkg::DATA_W-1:0] alpha;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corner values on a 2x2 window against the last columns
    set_config(Q_ONE, 0, 2, 62, 64);
    queue_req(r1mu_pkg::REQ_WR_X, 0, 63, Q_MAX);
    queue_req(r1mu_pkg::REQ_WR_X, 1, 0, Q_MIN);
    queue_req(r1mu_pkg::REQ_WR_X, 63, 63, -1);
    queue_req(r1mu_pkg::REQ_WR_Y, 63, 62, Q_MAX);
    queue_req(r1mu_pkg::REQ_WR_Y, 0, 63, Q_MIN);
    queue_req(r1mu_pkg::REQ_WR_A, 0, 62, Q_MAX);
    queue_req(r1mu_pkg::REQ_WR_A, 1, 62, Q_MIN);
    queue_req(r1mu_pkg::REQ_WR_A, 0, 63, 0);
    queue_req(r1mu_pkg::REQ_WR_A, 1, 63, -1);
    queue_req(r1mu_pkg::REQ_WR_A, 63, 0, 32'sh5555_aaaa);
    queue_read(63, 0);
    for (int k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++) begin
      queue_req(k[r1mu_pkg::REQ_W-1:0], 63, 63, -1);
    end
    queue_req(r1mu_pkg::REQ_UPDATE, 0, 0, 0);
    queue_read(0, 62);
    queue_read(1, 62);
    queue_read(0, 63);
    queue_read(1, 63);
    // full-scale negative alpha clips the coefficients
    set_config(Q_MIN, 0, 2, 62, 64);
    queue_req(r1mu_pkg::REQ_UPDATE, 63, 63, Q_MAX);
    queue_read(1, 63);
    // empty window must still clear the clip flag
    set_config(Q_ONE, 2, 2, 62, 64);
    queue_req(r1mu_pkg::REQ_UPDATE, 63, 63, -1);
    queue_read(0, 62);

    phase = 0;
    while (queued_items < ITEM_TARGET) begin
      // every row over the last few columns
      tall = (phase == 2 || phase == 9);
      alpha = rand_q16();
      if (tall) begin
        rf = 0;
        re = ROWS;
        cf = COLS - 4;
        ce = COLS;
      end else begin
        pick_span(ROWS, rf, re);
        pick_span(COLS, cf, ce);
      end
      set_config(alpha, rf, re, cf, ce);
      fill_window();
      n = tall ? 8 : $urandom_range(20, 50);
      repeat (n) begin
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
          queue_req(r1mu_pkg::REQ_WR_X, pick_row(), $urandom_range(0, COLS - 1), rand_q16());
        end else if (sel < 9) begin
          queue_req(r1mu_pkg::REQ_WR_Y, $urandom_range(0, ROWS - 1), pick_col(), rand_q16());
        end else if (sel < 13) begin
          queue_req(r1mu_pkg::REQ_WR_A, pick_row(), pick_col(), rand_q16());
        end else if (sel < 15) begin
          queue_req(r1mu_pkg::REQ_UPDATE, $urandom_range(0, ROWS - 1),
                    $urandom_range(0, COLS - 1), $urandom);
        end else if (sel < 19) begin
          queue_read(pick_row(), pick_col());
        end else begin
          code = $urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST);
          queue_req(code[r1mu_pkg::REQ_W-1:0], $urandom_range(0, ROWS - 1),
                    $urandom_range(0, COLS - 1), $urandom);
        end
      end
      // close each phase with an update and a look at the result
      queue_req(r1mu_pkg::REQ_UPDATE, $urandom_range(0, ROWS - 1),
                $urandom_range(0, COLS - 1), $urandom);
      repeat (3) queue_read(pick_row(), pick_col());
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** rank_one_matrix_update: PASSED **");
    end else begin
      $display("** rank_one_matrix_update: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
design/r1mu_pkg.sv
design/r1mu_ram.sv
design/r1mu_ctrl.sv
design/r1mu_dp.sv
design/rank_one_matrix_update.sv
dv/rank_one_matrix_update_tb.sv
